// File: rtl/bcs_pkg.sv
// ----------------------------------------------------------------------------
// bcs_pkg
// Types, codes and constants shared by the battery charge supervisor files.
// ----------------------------------------------------------------------------
`default_nettype none

package bcs_pkg;

    localparam logic [3:0]  DISCHARGE_LIMIT = 4'd10;
    localparam logic [2:0]  READY_LIMIT     = 3'd5;

    localparam logic [12:0] MS_SCREEN       = 13'd5000;
    localparam logic [12:0] MS_HOT          = 13'd4000;
    localparam logic [10:0] MS_PER_POLL     = 11'd50;
    localparam logic [4:0]  POLLS_MAX       = 5'd20;
    localparam logic [15:0] SECONDS_MAX     = 16'hFFFF;
    localparam logic [16:0] STEP_SCREEN     = 17'd5;
    localparam logic [16:0] STEP_PLAIN      = 17'd1;

    localparam logic [1:0]  VERDICT_KEEP    = 2'd0;
    localparam logic [1:0]  VERDICT_BOOT    = 2'd1;
    localparam logic [1:0]  VERDICT_DOWN    = 2'd2;

    localparam logic [2:0]  CAUSE_NONE      = 3'd0;
    localparam logic [2:0]  CAUSE_NO_CABLE  = 3'd1;
    localparam logic [2:0]  CAUSE_HOT       = 3'd2;
    localparam logic [2:0]  CAUSE_COLD      = 3'd3;
    localparam logic [2:0]  CAUSE_DISCHARGE = 3'd4;
    localparam logic [2:0]  CAUSE_OVERTIME  = 3'd5;
    localparam logic [2:0]  CAUSE_SENSOR    = 3'd6;

    localparam logic [1:0]  SCREEN_NONE     = 2'd0;
    localparam logic [1:0]  SCREEN_LOW      = 2'd1;
    localparam logic [1:0]  SCREEN_CHARGING = 2'd2;
    localparam logic [1:0]  SCREEN_HOT      = 2'd3;

    localparam logic [2:0]  CFG_BATTERY_HOT = 3'd0;
    localparam logic [2:0]  CFG_BATTERY_COLD = 3'd1;
    localparam logic [2:0]  CFG_DEVICE_HOT  = 3'd2;
    localparam logic [2:0]  CFG_BOOT_MV     = 3'd3;
    localparam logic [2:0]  CFG_BOOT_PCT    = 3'd4;
    localparam logic [2:0]  CFG_SPLASH_MV   = 3'd5;
    localparam logic [2:0]  CFG_MAX_SECONDS = 3'd6;

    typedef enum logic [1:0] {
        PH_INIT,
        PH_CHARGE,
        PH_BOOT,
        PH_DOWN
    } t_phase;

    typedef enum logic [1:0] {
        ACT_KEEP,
        ACT_BOOT,
        ACT_DOWN,
        ACT_HOLD
    } t_act;

    typedef struct packed {
        logic [12:0]        voltage_mv;
        logic [6:0]         capacity_pct;
        logic signed [15:0] current_ma;
        logic signed [7:0]  battery_temp_c;
        logic [7:0]         board_temp_c;
        logic               board_temp_failed;
        logic               vbus_present;
        logic               mains_adapter;
        logic               key_pressed;
        logic [4:0]         key_polls;
    } t_in;

    typedef struct packed {
        logic [1:0]  verdict;
        logic [2:0]  cause;
        logic [1:0]  screen;
        logic [12:0] display_ms;
        logic [15:0] seconds_out;
    } t_out;

    typedef struct packed {
        logic signed [7:0] battery_hot_limit;
        logic signed [7:0] battery_cold_limit;
        logic [7:0]        device_hot_limit;
        logic [12:0]       boot_voltage_mv;
        logic [6:0]        boot_capacity_pct;
        logic [12:0]       splash_voltage_mv;
        logic [15:0]       max_charge_seconds;
    } t_cfg;

    typedef struct packed {
        t_phase      phase;
        logic [3:0]  discharge_streak;
        logic [2:0]  ready_streak;
        logic [15:0] elapsed_seconds;
        logic        screen_shown;
        logic [2:0]  held_cause;
    } t_state;

endpackage

`default_nettype wire

// File: rtl/bcs_step.sv
// ----------------------------------------------------------------------------
// bcs_step
// Decision logic for one poll sample: result word and next supervisor state.
// ----------------------------------------------------------------------------
`default_nettype none

module bcs_step (
    input  var bcs_pkg::t_cfg   i_cfg,
    input  var bcs_pkg::t_state i_state,
    input  var bcs_pkg::t_in    i_item,
    output bcs_pkg::t_state     o_next_state,
    output bcs_pkg::t_out       o_result
);

    logic          is_ready;
    logic          may_show;
    logic          cur_pos;
    logic          bat_hot;
    logic          bat_cold;
    logic          dev_hot;
    logic          dis_stop;
    logic          overtime;
    logic          rdy_boot;
    logic          show_now;
    logic [1:0]    pic;
    logic [4:0]    polls;
    logic [10:0]   poll_ms;
    logic [12:0]   key_ms;
    logic [16:0]   sec_sum;
    logic [15:0]   sec_next;
    bcs_pkg::t_act act;
    logic [2:0]    act_cause;

    assign is_ready = (i_item.voltage_mv >= i_cfg.boot_voltage_mv)
                   && (i_item.capacity_pct >= i_cfg.boot_capacity_pct);
    assign may_show = (i_item.voltage_mv > i_cfg.splash_voltage_mv) || i_item.mains_adapter;
    assign cur_pos  = !i_item.current_ma[15] && (i_item.current_ma != 16'sd0);
    assign pic      = cur_pos ? bcs_pkg::SCREEN_CHARGING : bcs_pkg::SCREEN_LOW;
    assign bat_hot  = i_item.battery_temp_c > i_cfg.battery_hot_limit;
    assign bat_cold = i_item.battery_temp_c < i_cfg.battery_cold_limit;
    assign dev_hot  = i_item.board_temp_c >= i_cfg.device_hot_limit;
    assign dis_stop = !cur_pos && (i_state.discharge_streak >= bcs_pkg::DISCHARGE_LIMIT);
    assign overtime = i_state.elapsed_seconds > i_cfg.max_charge_seconds;
    assign rdy_boot = is_ready && (i_state.ready_streak >= bcs_pkg::READY_LIMIT);
    assign show_now = (i_item.key_pressed || !i_state.screen_shown) && may_show;

    assign polls    = (i_item.key_polls > bcs_pkg::POLLS_MAX) ? bcs_pkg::POLLS_MAX
                                                              : i_item.key_polls;
    assign poll_ms  = {6'd0, polls} * bcs_pkg::MS_PER_POLL;
    assign key_ms   = bcs_pkg::MS_SCREEN - {2'd0, poll_ms};
    assign sec_sum  = {1'b0, i_state.elapsed_seconds}
                    + (show_now ? bcs_pkg::STEP_SCREEN : bcs_pkg::STEP_PLAIN);
    assign sec_next = sec_sum[16] ? bcs_pkg::SECONDS_MAX : sec_sum[15:0];

    always_comb begin
        act       = bcs_pkg::ACT_KEEP;
        act_cause = bcs_pkg::CAUSE_NONE;
        unique case (i_state.phase)
            bcs_pkg::PH_INIT: begin
                if (i_item.board_temp_failed) begin
                    act       = bcs_pkg::ACT_DOWN;
                    act_cause = bcs_pkg::CAUSE_SENSOR;
                end else if (bat_hot || dev_hot) begin
                    act       = bcs_pkg::ACT_DOWN;
                    act_cause = bcs_pkg::CAUSE_HOT;
                end else if (is_ready) begin
                    act       = bcs_pkg::ACT_BOOT;
                end
            end
            bcs_pkg::PH_CHARGE: begin
                if (!i_item.vbus_present) begin
                    act       = bcs_pkg::ACT_DOWN;
                    act_cause = bcs_pkg::CAUSE_NO_CABLE;
                end else if (i_item.board_temp_failed) begin
                    act       = bcs_pkg::ACT_DOWN;
                    act_cause = bcs_pkg::CAUSE_SENSOR;
                end else if (bat_hot) begin
                    act       = bcs_pkg::ACT_DOWN;
                    act_cause = bcs_pkg::CAUSE_HOT;
                end else if (bat_cold) begin
                    act       = bcs_pkg::ACT_DOWN;
                    act_cause = bcs_pkg::CAUSE_COLD;
                end else if (dis_stop) begin
                    act       = bcs_pkg::ACT_DOWN;
                    act_cause = bcs_pkg::CAUSE_DISCHARGE;
                end else if (overtime) begin
                    act       = bcs_pkg::ACT_DOWN;
                    act_cause = bcs_pkg::CAUSE_OVERTIME;
                end else if (rdy_boot) begin
                    act       = bcs_pkg::ACT_BOOT;
                end
            end
            bcs_pkg::PH_BOOT, bcs_pkg::PH_DOWN: begin
                act       = bcs_pkg::ACT_HOLD;
                act_cause = i_state.held_cause;
            end
            default: begin
                act       = bcs_pkg::ACT_HOLD;
                act_cause = i_state.held_cause;
            end
        endcase
    end

    always_comb begin
        o_next_state = i_state;
        unique case (act)
            bcs_pkg::ACT_BOOT: begin
                o_next_state.phase      = bcs_pkg::PH_BOOT;
                o_next_state.held_cause = act_cause;
            end
            bcs_pkg::ACT_DOWN: begin
                o_next_state.phase      = bcs_pkg::PH_DOWN;
                o_next_state.held_cause = act_cause;
            end
            bcs_pkg::ACT_KEEP: begin
                if (i_state.phase == bcs_pkg::PH_INIT) begin
                    o_next_state.phase        = bcs_pkg::PH_CHARGE;
                    o_next_state.screen_shown = i_state.screen_shown | may_show;
                end else begin
                    o_next_state.discharge_streak = cur_pos ? 4'd0
                                                  : i_state.discharge_streak + 4'd1;
                    o_next_state.ready_streak     = is_ready ? i_state.ready_streak + 3'd1
                                                  : 3'd0;
                    o_next_state.screen_shown     = i_state.screen_shown | show_now;
                    o_next_state.elapsed_seconds  = sec_next;
                end
            end
            bcs_pkg::ACT_HOLD: begin
                o_next_state = i_state;
            end
            default: begin
                o_next_state = i_state;
            end
        endcase
    end

    always_comb begin
        o_result             = '0;
        o_result.cause       = act_cause;
        o_result.seconds_out = i_state.elapsed_seconds;
        unique case (act)
            bcs_pkg::ACT_BOOT: begin
                o_result.verdict = bcs_pkg::VERDICT_BOOT;
            end
            bcs_pkg::ACT_DOWN: begin
                o_result.verdict = bcs_pkg::VERDICT_DOWN;
                if (i_state.phase == bcs_pkg::PH_INIT && act_cause == bcs_pkg::CAUSE_HOT) begin
                    o_result.screen     = bcs_pkg::SCREEN_HOT;
                    o_result.display_ms = bcs_pkg::MS_HOT;
                end
            end
            bcs_pkg::ACT_KEEP: begin
                o_result.verdict = bcs_pkg::VERDICT_KEEP;
                if (i_state.phase == bcs_pkg::PH_INIT) begin
                    if (may_show) begin
                        o_result.screen     = pic;
                        o_result.display_ms = bcs_pkg::MS_SCREEN;
                    end
                end else begin
                    o_result.seconds_out = sec_next;
                    if (show_now) begin
                        o_result.screen     = pic;
                        o_result.display_ms = key_ms;
                    end
                end
            end
            bcs_pkg::ACT_HOLD: begin
                o_result.verdict = (i_state.phase == bcs_pkg::PH_BOOT)
                                 ? bcs_pkg::VERDICT_BOOT : bcs_pkg::VERDICT_DOWN;
            end
            default: begin
                o_result.verdict = bcs_pkg::VERDICT_DOWN;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/battery_charge_supervisor.sv
// ----------------------------------------------------------------------------
// battery_charge_supervisor
// Charge supervision verdicts from battery poll samples.
// ----------------------------------------------------------------------------
// Each accepted sample gives exactly one result word. A sample is taken into
// an input register and evaluated by compare logic against the supervisor
// state; its result word lands in an output register at the same edge at which
// the state updates, and one sample can be accepted every clock cycle while no
// result word waits on the output. A result word that waits on the output
// holds the input register, which then holds the input channel. Configuration
// writes take effect at the next edge and should only be made while the block
// is idle.
`default_nettype none

module battery_charge_supervisor (
    input  var logic          i_clk,
    input  var logic          i_rst_n,
    input  var logic          i_valid,
    output logic              o_ready,
    input  var bcs_pkg::t_in  i_data,
    output logic              o_valid,
    input  var logic          i_ready,
    output bcs_pkg::t_out     o_data,
    input  var logic          i_cfg_we,
    input  var logic [2:0]    i_cfg_idx,
    input  var logic [15:0]   i_cfg_wdata
);

    bcs_pkg::t_cfg   r_cfg;
    bcs_pkg::t_state r_state;
    bcs_pkg::t_state n_state;
    bcs_pkg::t_in    r_s1;
    logic            r_s1_valid;
    bcs_pkg::t_out   r_out;
    bcs_pkg::t_out   n_out;
    logic            r_out_valid;
    logic            s1_go;

    assign s1_go   = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_s1_valid || s1_go;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.battery_hot_limit  <= 8'sd59;
            r_cfg.battery_cold_limit <= -8'sd19;
            r_cfg.device_hot_limit   <= 8'd64;
            r_cfg.boot_voltage_mv    <= 13'd3430;
            r_cfg.boot_capacity_pct  <= 7'd2;
            r_cfg.splash_voltage_mv  <= 13'd3100;
            r_cfg.max_charge_seconds <= 16'd18000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bcs_pkg::CFG_BATTERY_HOT:  r_cfg.battery_hot_limit  <= i_cfg_wdata[7:0];
                bcs_pkg::CFG_BATTERY_COLD: r_cfg.battery_cold_limit <= i_cfg_wdata[7:0];
                bcs_pkg::CFG_DEVICE_HOT:   r_cfg.device_hot_limit   <= i_cfg_wdata[7:0];
                bcs_pkg::CFG_BOOT_MV:      r_cfg.boot_voltage_mv    <= i_cfg_wdata[12:0];
                bcs_pkg::CFG_BOOT_PCT:     r_cfg.boot_capacity_pct  <= i_cfg_wdata[6:0];
                bcs_pkg::CFG_SPLASH_MV:    r_cfg.splash_voltage_mv  <= i_cfg_wdata[12:0];
                bcs_pkg::CFG_MAX_SECONDS:  r_cfg.max_charge_seconds <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_s1 <= i_data;
        end
    end

    bcs_step u_step (
        .i_cfg        (r_cfg),
        .i_state      (r_state),
        .i_item       (r_s1),
        .o_next_state (n_state),
        .o_result     (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase            <= bcs_pkg::PH_INIT;
            r_state.discharge_streak <= 4'd0;
            r_state.ready_streak     <= 3'd0;
            r_state.elapsed_seconds  <= 16'd0;
            r_state.screen_shown     <= 1'b0;
            r_state.held_cause       <= bcs_pkg::CAUSE_NONE;
            r_out_valid              <= 1'b0;
        end else if (s1_go) begin
            r_state     <= n_state;
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    a_held_boot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == bcs_pkg::PH_BOOT |=> r_state.phase == bcs_pkg::PH_BOOT)
        else $error("boot verdict was not held");

    a_held_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == bcs_pkg::PH_DOWN |=> r_state.phase == bcs_pkg::PH_DOWN)
        else $error("shutdown verdict was not held");

    a_stall_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> r_s1_valid && r_out_valid && !i_ready)
        else $error("input stalled without a blocked output word");

    a_keep_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.verdict == bcs_pkg::VERDICT_KEEP
        |-> o_data.cause == bcs_pkg::CAUSE_NONE)
        else $error("keep verdict carries a cause");
`endif

endmodule

`default_nettype wire

// File: verif/battery_charge_supervisor_tb.sv
// ----------------------------------------------------------------------------
// battery_charge_supervisor_tb
// Self-checking bench for the battery charge supervisor.
// ----------------------------------------------------------------------------
// Poll samples go in through a valid/ready channel and result words are read
// from a second valid/ready channel, both throttled at random. A scoreboard
// keeps its own copy of the supervisor state and registers and predicts
// every result word in order. After reset the bench takes the block through
// the initial check into charging and runs a directed set of edge cases. It
// then runs long charging sessions under several register settings, with
// discharge and ready streaks that come close to their limits. Last, it ends
// the session by one randomly chosen cause and checks the held verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_charge_supervisor_tb;

    timeunit 1ns;
    timeprecision 1ps;

    class verdict_book;
        bcs_pkg::t_cfg   regs;
        bcs_pkg::t_state sup;
        bcs_pkg::t_out   verdicts_due[$];
        int              fails;
        int              checked;

        function new();
            regs.battery_hot_limit  = 8'sd59;
            regs.battery_cold_limit = -8'sd19;
            regs.device_hot_limit   = 8'd64;
            regs.boot_voltage_mv    = 13'd3430;
            regs.boot_capacity_pct  = 7'd2;
            regs.splash_voltage_mv  = 13'd3100;
            regs.max_charge_seconds = 16'd18000;
            sup = '0;
            fails = 0;
            checked = 0;
        endfunction

        function bcs_pkg::t_out close_session(bcs_pkg::t_phase ph, logic [2:0] why,
                                              logic [1:0] scr, logic [12:0] ms);
            bcs_pkg::t_out r;
            sup.phase = ph;
            sup.held_cause = why;
            r.verdict = (ph == bcs_pkg::PH_BOOT) ? bcs_pkg::VERDICT_BOOT
                                                 : bcs_pkg::VERDICT_DOWN;
            r.cause = why;
            r.screen = scr;
            r.display_ms = ms;
            r.seconds_out = sup.elapsed_seconds;
            return r;
        endfunction

        function void note_sample(bcs_pkg::t_in w);
            bcs_pkg::t_out r;
            logic          ready;
            logic          may_show;
            logic          boot;
            logic          show;
            logic [1:0]    pic;
            logic [4:0]    polls;
            logic [2:0]    why;
            logic [16:0]   sum;
            r = '0;
            ready = w.voltage_mv >= regs.boot_voltage_mv &&
                    w.capacity_pct >= regs.boot_capacity_pct;
            may_show = w.voltage_mv > regs.splash_voltage_mv || w.mains_adapter;
            pic = (w.current_ma > 0) ? bcs_pkg::SCREEN_CHARGING : bcs_pkg::SCREEN_LOW;
            polls = (w.key_polls > bcs_pkg::POLLS_MAX) ? bcs_pkg::POLLS_MAX : w.key_polls;
            why = bcs_pkg::CAUSE_NONE;
            boot = 1'b0;
            if (sup.phase == bcs_pkg::PH_BOOT || sup.phase == bcs_pkg::PH_DOWN) begin
                r = close_session(sup.phase, sup.held_cause, bcs_pkg::SCREEN_NONE, '0);
            end else if (sup.phase == bcs_pkg::PH_INIT) begin
                if (w.board_temp_failed) begin
                    r = close_session(bcs_pkg::PH_DOWN, bcs_pkg::CAUSE_SENSOR,
                                      bcs_pkg::SCREEN_NONE, '0);
                end else if (w.battery_temp_c > regs.battery_hot_limit ||
                             w.board_temp_c >= regs.device_hot_limit) begin
                    r = close_session(bcs_pkg::PH_DOWN, bcs_pkg::CAUSE_HOT,
                                      bcs_pkg::SCREEN_HOT, bcs_pkg::MS_HOT);
                end else if (ready) begin
                    r = close_session(bcs_pkg::PH_BOOT, bcs_pkg::CAUSE_NONE,
                                      bcs_pkg::SCREEN_NONE, '0);
                end else begin
                    sup.phase = bcs_pkg::PH_CHARGE;
                    r.verdict = bcs_pkg::VERDICT_KEEP;
                    if (may_show) begin
                        sup.screen_shown = 1'b1;
                        r.screen = pic;
                        r.display_ms = bcs_pkg::MS_SCREEN;
                    end
                    r.seconds_out = sup.elapsed_seconds;
                end
            end else begin
                if (!w.vbus_present) begin
                    why = bcs_pkg::CAUSE_NO_CABLE;
                end else if (w.board_temp_failed) begin
                    why = bcs_pkg::CAUSE_SENSOR;
                end else if (w.battery_temp_c > regs.battery_hot_limit) begin
                    why = bcs_pkg::CAUSE_HOT;
                end else if (w.battery_temp_c < regs.battery_cold_limit) begin
                    why = bcs_pkg::CAUSE_COLD;
                end else begin
                    if (w.current_ma <= 0) begin
                        if (sup.discharge_streak >= bcs_pkg::DISCHARGE_LIMIT) begin
                            why = bcs_pkg::CAUSE_DISCHARGE;
                        end else begin
                            sup.discharge_streak = sup.discharge_streak + 4'd1;
                        end
                    end else begin
                        sup.discharge_streak = '0;
                    end
                    if (why == bcs_pkg::CAUSE_NONE &&
                        sup.elapsed_seconds > regs.max_charge_seconds) begin
                        why = bcs_pkg::CAUSE_OVERTIME;
                    end
                    if (why == bcs_pkg::CAUSE_NONE) begin
                        if (ready) begin
                            if (sup.ready_streak >= bcs_pkg::READY_LIMIT) begin
                                boot = 1'b1;
                            end else begin
                                sup.ready_streak = sup.ready_streak + 3'd1;
                            end
                        end else begin
                            sup.ready_streak = '0;
                        end
                    end
                end
                if (why != bcs_pkg::CAUSE_NONE) begin
                    r = close_session(bcs_pkg::PH_DOWN, why, bcs_pkg::SCREEN_NONE, '0);
                end else if (boot) begin
                    r = close_session(bcs_pkg::PH_BOOT, bcs_pkg::CAUSE_NONE,
                                      bcs_pkg::SCREEN_NONE, '0);
                end else begin
                    show = (w.key_pressed || !sup.screen_shown) && may_show;
                    r.verdict = bcs_pkg::VERDICT_KEEP;
                    if (show) begin
                        sup.screen_shown = 1'b1;
                        r.screen = pic;
                        r.display_ms = bcs_pkg::MS_SCREEN
                                     - 13'(polls * bcs_pkg::MS_PER_POLL);
                    end
                    sum = {1'b0, sup.elapsed_seconds}
                        + (show ? bcs_pkg::STEP_SCREEN : bcs_pkg::STEP_PLAIN);
                    sup.elapsed_seconds = (sum > {1'b0, bcs_pkg::SECONDS_MAX})
                                        ? bcs_pkg::SECONDS_MAX : sum[15:0];
                    r.seconds_out = sup.elapsed_seconds;
                end
            end
            verdicts_due.push_back(r);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                fails++;
            end
        endfunction

        function void check_verdict(bcs_pkg::t_out got);
            bcs_pkg::t_out want;
            if (verdicts_due.size() == 0) begin
                $error("result word arrived with nothing expected");
                fails++;
                return;
            end
            want = verdicts_due.pop_front();
            checked++;
            compare_field("verdict", want.verdict, got.verdict);
            compare_field("cause", want.cause, got.cause);
            compare_field("screen", want.screen, got.screen);
            compare_field("display_ms", want.display_ms, got.display_ms);
            compare_field("seconds_out", want.seconds_out, got.seconds_out);
        endfunction
    endclass

    typedef enum {
        END_NO_CABLE,
        END_SENSOR,
        END_HOT,
        END_COLD,
        END_DISCHARGE,
        END_OVERTIME,
        END_BOOT
    } t_ending;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic          o_ready;
    bcs_pkg::t_in  i_data = '0;
    logic          o_valid;
    logic          i_ready = 1'b0;
    bcs_pkg::t_out o_data;
    logic          i_cfg_we = 1'b0;
    logic [2:0]    i_cfg_idx = '0;
    logic [15:0]   i_cfg_wdata = '0;

    verdict_book book;
    bit          steady = 1'b1;
    int          sent = 0;
    t_ending     ending;

    battery_charge_supervisor u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            book.check_verdict(o_data);
        end
        i_ready <= steady || ($urandom_range(0, 99) >= 16);
    end

    function automatic bcs_pkg::t_cfg make_cfg(int hot, int cold, int dev, int bv, int bc,
                                               int sv, int mx);
        bcs_pkg::t_cfg c;
        c.battery_hot_limit  = 8'(hot);
        c.battery_cold_limit = 8'(cold);
        c.device_hot_limit   = 8'(dev);
        c.boot_voltage_mv    = 13'(bv);
        c.boot_capacity_pct  = 7'(bc);
        c.splash_voltage_mv  = 13'(sv);
        c.max_charge_seconds = 16'(mx);
        return c;
    endfunction

    function automatic bcs_pkg::t_in charging_sample(bit sag, bit full, bit lethal);
        bcs_pkg::t_in w;
        int           lo;
        int           hi;
        int           amp;
        logic         ready;
        lo = book.regs.battery_cold_limit;
        hi = book.regs.battery_hot_limit;
        w.voltage_mv = 13'($urandom);
        w.capacity_pct = 7'($urandom_range(0, 100));
        w.board_temp_c = 8'($urandom);
        w.board_temp_failed = 1'b0;
        w.vbus_present = 1'b1;
        w.mains_adapter = 1'($urandom);
        w.key_pressed = 1'($urandom);
        w.key_polls = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(21, 31))
                                                   : 5'($urandom_range(0, 20));
        case ($urandom_range(0, 9))
            0: w.battery_temp_c = 8'(hi);
            1: w.battery_temp_c = 8'(lo);
            default: w.battery_temp_c = 8'(lo + int'($urandom_range(0, hi - lo)));
        endcase
        if (sag || $urandom_range(0, 99) < 35) begin
            amp = $urandom_range(0, 32768);
            w.current_ma = 16'(-amp);
        end else begin
            w.current_ma = 16'($urandom_range(1, 32767));
        end
        if (!(sag && lethal) && w.current_ma <= 0 &&
            book.sup.discharge_streak >= bcs_pkg::DISCHARGE_LIMIT) begin
            w.current_ma = 16'($urandom_range(1, 32767));
        end
        if (full || $urandom_range(0, 1) == 1) begin
            w.voltage_mv = 13'($urandom_range(book.regs.boot_voltage_mv, 8191));
            w.capacity_pct = 7'($urandom_range(book.regs.boot_capacity_pct, 100));
        end
        ready = w.voltage_mv >= book.regs.boot_voltage_mv &&
                w.capacity_pct >= book.regs.boot_capacity_pct;
        if (!(full && lethal) && ready && book.sup.ready_streak >= bcs_pkg::READY_LIMIT) begin
            if (book.regs.boot_voltage_mv != 0) begin
                w.voltage_mv = 13'($urandom_range(0, book.regs.boot_voltage_mv - 1));
            end else begin
                w.capacity_pct = 7'($urandom_range(0, book.regs.boot_capacity_pct - 1));
            end
        end
        return w;
    endfunction

    task automatic send_word(input bcs_pkg::t_in w);
        while (!steady && $urandom_range(0, 99) < 16) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= w;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        book.note_sample(w);
        sent++;
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (book.verdicts_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_regs(input bcs_pkg::t_cfg c);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= bcs_pkg::CFG_BATTERY_HOT;
        i_cfg_wdata <= 16'(c.battery_hot_limit);
        @(posedge i_clk);
        i_cfg_idx <= bcs_pkg::CFG_BATTERY_COLD;
        i_cfg_wdata <= 16'(c.battery_cold_limit);
        @(posedge i_clk);
        i_cfg_idx <= bcs_pkg::CFG_DEVICE_HOT;
        i_cfg_wdata <= 16'(c.device_hot_limit);
        @(posedge i_clk);
        i_cfg_idx <= bcs_pkg::CFG_BOOT_MV;
        i_cfg_wdata <= 16'(c.boot_voltage_mv);
        @(posedge i_clk);
        i_cfg_idx <= bcs_pkg::CFG_BOOT_PCT;
        i_cfg_wdata <= 16'(c.boot_capacity_pct);
        @(posedge i_clk);
        i_cfg_idx <= bcs_pkg::CFG_SPLASH_MV;
        i_cfg_wdata <= 16'(c.splash_voltage_mv);
        @(posedge i_clk);
        i_cfg_idx <= bcs_pkg::CFG_MAX_SECONDS;
        i_cfg_wdata <= c.max_charge_seconds;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        book.regs = c;
    endtask

    task automatic run_charging(input int count, input int calm_lo, input int calm_hi);
        int burst;
        burst = 0;
        for (int i = 0; i < count; i++) begin
            steady = (i >= calm_lo && i < calm_hi);
            if (burst == 0 && $urandom_range(0, 39) == 0) begin
                burst = $urandom_range(6, 12);
            end
            send_word(charging_sample(burst > 0, 1'b0, 1'b0));
            if (burst > 0) begin
                burst--;
            end
        end
    endtask

    initial begin
        bcs_pkg::t_in  b;
        bcs_pkg::t_in  w;
        bcs_pkg::t_cfg c3;
        book = new;
        ending = t_ending'($urandom_range(0, 6));
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        program_regs(make_cfg(59, -19, 64, 3430, 2, 3100, 18000));

        steady = 1'b1;
        b.voltage_mv = 13'd3000;
        b.capacity_pct = 7'd1;
        b.current_ma = 16'sd500;
        b.battery_temp_c = 8'sd25;
        b.board_temp_c = 8'd30;
        b.board_temp_failed = 1'b0;
        b.vbus_present = 1'b1;
        b.mains_adapter = 1'b0;
        b.key_pressed = 1'b0;
        b.key_polls = 5'd20;

        w = b;
        w.battery_temp_c = 8'sd59;
        w.board_temp_c = 8'd63;
        case ($urandom_range(0, 2))
            0: begin
                w.voltage_mv = 13'd3200;
                w.current_ma = -16'sd100;
            end
            1: begin
                w.voltage_mv = 13'd3200;
                w.current_ma = 16'sd800;
            end
            default: w.voltage_mv = 13'd3000;
        endcase
        send_word(w);

        send_word(b);
        w = b;
        w.key_pressed = 1'b1;
        w.voltage_mv = 13'd3101;
        w.key_polls = 5'd0;
        send_word(w);
        w.key_polls = 5'd20;
        w.current_ma = 16'sd0;
        send_word(w);
        w = b;
        w.key_pressed = 1'b1;
        w.mains_adapter = 1'b1;
        w.voltage_mv = 13'd0;
        w.key_polls = 5'd31;
        w.current_ma = -16'sd32768;
        send_word(w);
        w = b;
        w.key_pressed = 1'b1;
        w.voltage_mv = 13'd3100;
        w.current_ma = 16'sd32767;
        send_word(w);
        w = b;
        w.battery_temp_c = 8'sd59;
        send_word(w);
        w.battery_temp_c = -8'sd19;
        w.board_temp_c = 8'd255;
        send_word(w);
        for (int k = 0; k < 5; k++) begin
            w = b;
            w.voltage_mv = k[0] ? 13'd8191 : 13'd3430;
            w.capacity_pct = k[0] ? 7'd100 : 7'd2;
            send_word(w);
        end
        w = b;
        w.voltage_mv = 13'd3429;
        w.capacity_pct = 7'd100;
        send_word(w);
        w.voltage_mv = 13'd3430;
        w.capacity_pct = 7'd1;
        send_word(w);
        w = b;
        w.key_pressed = 1'b1;
        w.voltage_mv = 13'd5000;
        w.key_polls = 5'd7;
        send_word(w);

        run_charging(440, 0, 0);
        drain_results();
        program_regs(make_cfg(127, -128, 255, 8191, 100, 0, 65535));
        run_charging(440, 150, 300);
        drain_results();
        program_regs(make_cfg(10, 10, 0, 1, 0, 8191, 30000));
        run_charging(440, 0, 0);
        drain_results();
        c3 = make_cfg($urandom_range(0, 100), -int'($urandom_range(1, 100)),
                      $urandom_range(0, 255), $urandom_range(1000, 5000),
                      $urandom_range(1, 100), $urandom_range(0, 8191), 40000);
        program_regs(c3);
        run_charging(60, 0, 0);

        if (ending == END_OVERTIME) begin
            drain_results();
            c3.max_charge_seconds = '0;
            program_regs(c3);
        end
        while (book.sup.phase == bcs_pkg::PH_CHARGE) begin
            case (ending)
                END_DISCHARGE: w = charging_sample(1'b1, 1'b0, 1'b1);
                END_BOOT:      w = charging_sample(1'b0, 1'b1, 1'b1);
                default:       w = charging_sample(1'b0, 1'b0, 1'b0);
            endcase
            case (ending)
                END_NO_CABLE: w.vbus_present = 1'b0;
                END_SENSOR:   w.board_temp_failed = 1'b1;
                END_HOT:      w.battery_temp_c = book.regs.battery_hot_limit + 8'sd1;
                END_COLD:     w.battery_temp_c = book.regs.battery_cold_limit - 8'sd1;
                default:      ;
            endcase
            send_word(w);
        end

        for (int i = 0; i < 60; i++) begin
            w.voltage_mv = 13'($urandom);
            w.capacity_pct = 7'($urandom_range(0, 100));
            w.current_ma = 16'($urandom);
            w.battery_temp_c = 8'($urandom);
            w.board_temp_c = 8'($urandom);
            w.board_temp_failed = 1'($urandom);
            w.vbus_present = 1'($urandom);
            w.mains_adapter = 1'($urandom);
            w.key_pressed = 1'($urandom);
            w.key_polls = 5'($urandom_range(0, 31));
            send_word(w);
        end
        drain_results();

        $display("tb: %0d samples sent, %0d result words checked, %0d mismatches",
                 sent, book.checked, book.fails);
        $display("tb: charging session closed by %s", ending.name());
        if (book.fails == 0 && book.verdicts_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
